/* rtl/mpss_pkg.sv */
// Shared state codes for the maximal points sort/sweep unit.
package mpss_pkg;

  // Control state codes
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_MERGE = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_COPY  = 3'd4;

endpackage

/* rtl/maximal_points_sort_sweep_unit.sv */
// Top level: point loader, memory-based merge sort, maxima sweep and emitter.
//
// Channel | Dir | Handshake        | Payload
// in_     | in  | tvalid / tready  | tdata {y,x}, tlast = set_last
// out_    | out | tvalid / tready  | tdata {y,x}, tlast = run_last, tuser = overflowed
//
// Loading takes one point per cycle. After the last point the set is sorted by
// ceil(log2 n) merge passes through the one-read-port point memories (registered
// read): each run pair is set up, then its points are merged one by one, with a
// copy back from scratch when the pass count is odd. The sweep from the top down
// and then the emitter follow; output stalls hold the emitter.
// Reset (synchronous, rst_n low) returns to loading with an empty set. The input
// is not taken while a set is being processed.
module maximal_points_sort_sweep_unit #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [((2*COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,   // point_x, point_y, zero fill
  input  logic                    in_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [((2*COORD_BITS + 7) / 8) * 8 - 1:0] out_tdata,  // max_x, max_y, zero fill
  output logic                    out_tlast,
  output logic                    out_tuser   // overflowed
);
  localparam int DW = ((2*COORD_BITS + 7) / 8) * 8;
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * COORD_BITS;

  typedef logic [PW-1:0] pt_t;

  // Point memory and scratch memory
  pt_t mem_a [MAX_POINTS];
  pt_t mem_b [MAX_POINTS];
  logic keep_mem [MAX_POINTS];

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [CW:0]   width_r, width_nxt;
  logic [CW:0]   lo_r, lo_nxt, i_r, i_nxt, j_r, j_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic          src_b_r, src_b_nxt;
  pt_t           pi_r, pi_nxt;
  logic signed [COORD_BITS-1:0] rmy_r, rmy_nxt, rmx_r, rmx_nxt;
  logic [CW-1:0] kept_r, kept_nxt, emc_r, emc_nxt;

  // Memory read port (shared) and write port
  logic          rd_b;
  logic [AW-1:0] rd_addr;
  pt_t           rd_a_q, rd_b_q;
  pt_t           rd_q;
  logic          rk_q;
  logic          wr_a_en, wr_b_en, wr_k_en, wr_k_val;
  logic [AW-1:0] wr_addr;
  pt_t           wr_data;

  // Output register
  logic          ov_r, ov_nxt;
  pt_t           od_r, od_nxt;
  logic          ol_r, ol_nxt, ou_r, ou_nxt;

  always_ff @(posedge clk) begin
    rd_a_q <= mem_a[rd_addr];
    rd_b_q <= mem_b[rd_addr];
    rk_q   <= keep_mem[rd_addr];
    if (wr_a_en) mem_a[wr_addr] <= wr_data;
    if (wr_b_en) mem_b[wr_addr] <= wr_data;
    if (wr_k_en) keep_mem[wr_addr] <= wr_k_val;
  end

  logic rd_b_sel_r;
  always_ff @(posedge clk) rd_b_sel_r <= rd_b;
  assign rd_q = rd_b_sel_r ? rd_b_q : rd_a_q;

  function automatic logic pt_le(pt_t a, pt_t b);
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    ax = a[COORD_BITS-1:0]; ay = a[PW-1:COORD_BITS];
    bx = b[COORD_BITS-1:0]; by = b[PW-1:COORD_BITS];
    if (ax != bx) return ax < bx;
    return ay <= by;
  endfunction

  assign in_tready  = (state_r == mpss_pkg::ST_LOAD);
  assign out_tvalid = ov_r;
  assign out_tdata  = DW'(od_r);
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

  logic [CW:0] n_ext;
  assign n_ext = {1'b0, cnt_r};

  // Main sequencer
  always_comb begin
    logic signed [COORD_BITS-1:0] py, px;
    logic keep;
    logic take_i;
    pt_t pj;
    state_nxt = state_r; cnt_nxt = cnt_r; drop_nxt = drop_r;
    width_nxt = width_r; lo_nxt = lo_r; i_nxt = i_r; j_nxt = j_r;
    mid_nxt = mid_r; hi_nxt = hi_r; k_nxt = k_r; ph_nxt = ph_r; src_b_nxt = src_b_r;
    pi_nxt = pi_r; rmy_nxt = rmy_r; rmx_nxt = rmx_r;
    kept_nxt = kept_r; emc_nxt = emc_r;
    ov_nxt = ov_r; od_nxt = od_r; ol_nxt = ol_r; ou_nxt = ou_r;
    rd_b = src_b_r; rd_addr = '0;
    wr_a_en = 1'b0; wr_b_en = 1'b0; wr_k_en = 1'b0; wr_k_val = 1'b0;
    wr_addr = '0; wr_data = '0;
    py = '0; px = '0; keep = 1'b0; take_i = 1'b0; pj = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      mpss_pkg::ST_LOAD: begin
        if (in_tvalid) begin
          if (n_ext < (CW+1)'(MAX_POINTS)) begin
            wr_a_en = 1'b1; wr_addr = AW'(cnt_r); wr_data = in_tdata[PW-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            src_b_nxt = 1'b0; width_nxt = (CW+1)'(1);
            lo_nxt = '0; ph_nxt = 2'd0;
            state_nxt = mpss_pkg::ST_MERGE;
          end
        end
      end

      // Merge pass: phase 0 sets up a run pair and fetches the left head,
      // 1 takes it and fetches the right head, 2 compares and writes
      mpss_pkg::ST_MERGE: begin
        if (width_r >= n_ext) begin
          if (src_b_r) begin
            state_nxt = mpss_pkg::ST_COPY; i_nxt = '0; ph_nxt = 2'd0;
          end else begin
            state_nxt = mpss_pkg::ST_SWEEP; i_nxt = n_ext; ph_nxt = 2'd0;
          end
        end else if (lo_r >= n_ext) begin
          width_nxt = width_r << 1; lo_nxt = '0; src_b_nxt = ~src_b_r;
        end else begin
          case (ph_r)
            2'd0: begin
              mid_nxt = (lo_r + width_r > n_ext) ? n_ext : lo_r + width_r;
              hi_nxt  = (lo_r + (width_r << 1) > n_ext) ? n_ext : lo_r + (width_r << 1);
              i_nxt = lo_r; k_nxt = CW'(lo_r);
              j_nxt = (lo_r + width_r > n_ext) ? n_ext : lo_r + width_r;
              rd_addr = AW'(lo_r); ph_nxt = 2'd1;
            end
            2'd1: begin
              pi_nxt = rd_q; rd_addr = AW'(j_r); ph_nxt = 2'd2;
            end
            default: begin
              pj = rd_q;
              if (i_r < mid_r && j_r < hi_r) take_i = pt_le(pi_r, pj);
              else take_i = (i_r < mid_r);
              wr_a_en = src_b_r; wr_b_en = ~src_b_r; wr_addr = AW'(k_r);
              wr_data = take_i ? pi_r : pj;
              k_nxt = k_r + 1'b1;
              if (take_i) i_nxt = i_r + 1'b1; else j_nxt = j_r + 1'b1;
              if ((i_r + j_r + 1'b1) >= mid_r + hi_r) begin
                lo_nxt = lo_r + (width_r << 1); ph_nxt = 2'd0;
              end else begin
                // Refetch both heads; the written side is the other memory
                rd_addr = take_i ? AW'(i_r + 1'b1) : AW'(i_r);
                j_nxt = take_i ? j_r : j_r + 1'b1;
                ph_nxt = 2'd1;
              end
            end
          endcase
        end
      end

      // Copy sorted data from scratch back into the point memory
      mpss_pkg::ST_COPY: begin
        rd_b = 1'b1;
        if (ph_r == 2'd0) begin
          rd_addr = AW'(i_r); ph_nxt = 2'd1;
        end else begin
          wr_a_en = 1'b1; wr_addr = AW'(i_r); wr_data = rd_q;
          if (i_r + 1'b1 >= n_ext) begin
            state_nxt = mpss_pkg::ST_SWEEP; i_nxt = n_ext; src_b_nxt = 1'b0;
          end else i_nxt = i_r + 1'b1;
          ph_nxt = 2'd0;
        end
      end

      // Sweep from the top down, marking kept points
      mpss_pkg::ST_SWEEP: begin
        rd_b = 1'b0;
        if (i_r == '0) begin
          state_nxt = mpss_pkg::ST_EMIT; i_nxt = '0; ph_nxt = 2'd0; emc_nxt = '0;
        end else if (ph_r == 2'd0) begin
          rd_addr = AW'(i_r - 1'b1); ph_nxt = 2'd1;
        end else begin
          px = rd_q[COORD_BITS-1:0]; py = rd_q[PW-1:COORD_BITS];
          keep = (i_r == n_ext) || (py > rmy_r) || (py == rmy_r && px == rmx_r);
          wr_k_en = 1'b1; wr_k_val = keep; wr_addr = AW'(i_r - 1'b1);
          if (keep) begin
            rmy_nxt = py; rmx_nxt = px; kept_nxt = kept_r + 1'b1;
          end
          i_nxt = i_r - 1'b1; ph_nxt = 2'd0;
        end
      end

      // Emit kept points in ascending order; the read address holds while stalled
      mpss_pkg::ST_EMIT: begin
        rd_b = 1'b0;
        rd_addr = AW'(i_r);
        if (i_r >= n_ext) begin
          state_nxt = mpss_pkg::ST_LOAD; cnt_nxt = '0; drop_nxt = 1'b0;
          kept_nxt = '0;
        end else if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (!rk_q) begin
          i_nxt = i_r + 1'b1; ph_nxt = 2'd0;
        end else if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; od_nxt = rd_q;
          ol_nxt = (emc_r + 1'b1 == kept_r); ou_nxt = drop_r;
          emc_nxt = emc_r + 1'b1; i_nxt = i_r + 1'b1; ph_nxt = 2'd0;
        end
      end

      default: state_nxt = mpss_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpss_pkg::ST_LOAD; cnt_r <= '0; drop_r <= 1'b0; ov_r <= 1'b0;
      kept_r <= '0; rmy_r <= '0; rmx_r <= '0; src_b_r <= 1'b0; ph_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; drop_r <= drop_nxt; ov_r <= ov_nxt;
      kept_r <= kept_nxt; rmy_r <= rmy_nxt; rmx_r <= rmx_nxt; src_b_r <= src_b_nxt;
      ph_r <= ph_nxt;
    end
    width_r <= width_nxt; lo_r <= lo_nxt; i_r <= i_nxt; j_r <= j_nxt;
    mid_r <= mid_nxt; hi_r <= hi_nxt; k_r <= k_nxt; pi_r <= pi_nxt;
    emc_r <= emc_nxt; od_r <= od_nxt; ol_r <= ol_nxt; ou_r <= ou_nxt;
  end

endmodule

/* rtl/maximal_points_sort_sweep_unit_chk.sv */
// Port-level checker for the maximal points unit, bound to the top level.
module maximal_points_sort_sweep_unit_chk #(
  parameter int DW = 32
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          in_tlast,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [DW-1:0] out_tdata,
  input logic          out_tlast,
  input logic          out_tuser
);
  // Handshake controls are always known
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_tvalid) && !$isunknown(in_tready)) else $error("unknown handshake");
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
    && $stable(out_tuser))
    else $error("stalled result changed");
  // Last accepted point closes loading
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready) else $error("input open after last");
  // After reset the unit is ready to load
  a_reset_ready: assert property (@(posedge clk)
    $rose(rst_n) |-> in_tready) else $error("not ready after reset");
endmodule

bind maximal_points_sort_sweep_unit maximal_points_sort_sweep_unit_chk #(.DW(DW)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast), .out_tuser(out_tuser));

/* tb/sv/tb_maximal_points_sort_sweep_unit.sv */
// Testbench for the maximal points sort/sweep unit: predicted maxima checked per set.
module tb_maximal_points_sort_sweep_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP   = 64;
  localparam int CBITS = 16;
  localparam int DW    = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CBITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   ovf;
  } maxima_t;

  // Predicts the maxima of each loaded set and holds them until they come out
  class maxima_scoreboard;
    coord_t  px[CAP];
    coord_t  py[CAP];
    int      count;
    bit      dropped;
    coord_t  top_y;
    coord_t  top_x;
    maxima_t pending[$];
    int      errors;

    function new();
      count = 0;
      dropped = 0;
      top_y = '0;
      top_x = '0;
      errors = 0;
    endfunction

    // Accepted input transaction: store the point, solve the set on last
    function void note_point(coord_t x, coord_t y, logic last);
      coord_t tx, ty;
      bit keep[CAP];
      int kept, emitted, j;
      maxima_t item;
      if (count < CAP) begin
        px[count] = x;
        py[count] = y;
        count++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      // sort by x, then y (insertion sort; equal keys are identical points)
      for (int i = 1; i < count; i++) begin
        tx = px[i];
        ty = py[i];
        j = i - 1;
        while (j >= 0 && (px[j] > tx || (px[j] == tx && py[j] > ty))) begin
          px[j+1] = px[j];
          py[j+1] = py[j];
          j--;
        end
        px[j+1] = tx;
        py[j+1] = ty;
      end
      // sweep from the largest x down
      kept = 0;
      for (int i = count - 1; i >= 0; i--) begin
        keep[i] = (i == count - 1) || (py[i] > top_y) ||
                  (py[i] == top_y && px[i] == top_x);
        if (keep[i]) begin
          top_y = py[i];
          top_x = px[i];
          kept++;
        end
      end
      emitted = 0;
      for (int i = 0; i < count; i++) begin
        if (keep[i]) begin
          emitted++;
          item = '{x: px[i], y: py[i], last: (emitted == kept), ovf: dropped};
          pending = {pending, item};
        end
      end
      count = 0;
      dropped = 0;
    endfunction

    // Accepted output transaction against the oldest expectation
    function void check_result(coord_t x, coord_t y, logic last, logic ovf);
      maxima_t e;
      if (pending.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", x, y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $error("max_x expected %0d actual %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("max_y expected %0d actual %0d", e.y, y);
        errors++;
      end
      if (last !== e.last) begin
        $error("run_last expected %0b actual %0b", e.last, last);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflowed expected %0b actual %0b", e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [DW-1:0] in_tdata;   // point_x, point_y
  logic          in_tlast;
  logic          out_tvalid;
  logic          out_tready;
  logic [DW-1:0] out_tdata;  // max_x, max_y
  logic          out_tlast;
  logic          out_tuser;  // overflowed

  maxima_scoreboard sb;
  bit quiet;
  int stall_left;
  int idle_cycles;

  maximal_points_sort_sweep_unit #(.MAX_POINTS(CAP), .COORD_BITS(CBITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sink side: check results, random stall bursts, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[15:0], out_tdata[31:16], out_tlast, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("maximal_points_sort_sweep_unit regression: fail");
        $finish;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Present one point and wait for its transaction
  task automatic send_point(input coord_t x, input coord_t y, input logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_point(x, y, last);
  endtask

  // Random coordinate: full range, or a narrow band that forces ties
  function automatic coord_t rand_coord(input bit narrow);
    if (narrow) return coord_t'($signed($urandom_range(0, 6)) - 3);
    return coord_t'($urandom);
  endfunction

  task automatic send_random_set(input int n);
    bit narrow;
    narrow = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(narrow), rand_coord(narrow), i == n - 1);
  endtask

  initial begin
    int sent;
    int n;
    sb = new();
    quiet = 0;
    stall_left = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single point, extremes, identical points, ties in x, equal y
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(16'sd3, 16'sd1, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b0);
    send_point(16'sd3, -16'sd2, 1'b0);
    send_point(16'sd1, 16'sd4, 1'b0);
    send_point(16'sd6, 16'sd4, 1'b1);
    send_point(-16'sd1, -16'sd1, 1'b0);
    send_point(-16'sd2, -16'sd1, 1'b0);
    send_point(-16'sd3, 16'sd0, 1'b1);

    // Over capacity, dropped last still starts the set
    send_random_set(CAP + 3);
    // Exactly full
    send_random_set(CAP);

    // Random sets, mostly small, up to about 250 points in all
    sent = 15 + 2 * CAP + 3;
    while (sent < 250) begin
      if (sent > 210) quiet = 1;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, CAP + 2) : $urandom_range(1, 10);
      send_random_set(n);
      sent += n;
    end
    in_tvalid <= 1'b0;

    // Drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("maximal_points_sort_sweep_unit regression: pass");
    end else begin
      $display("maximal_points_sort_sweep_unit regression: fail");
    end
    $finish;
  end
endmodule
